// File: src/response_spectrum_peak_bank_assert.svh
// assertion macros for the response spectrum peak bank
`ifndef RESPONSE_SPECTRUM_PEAK_BANK_ASSERT_SVH
`define RESPONSE_SPECTRUM_PEAK_BANK_ASSERT_SVH

// check while out of reset
`define RSPB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define RSPB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/rspb_pkg.sv
// ----------------------------------------------------------------------------
// rspb_pkg
// types, constants and arithmetic helpers of the response spectrum peak bank
// ----------------------------------------------------------------------------
package rspb_pkg;

	localparam int LANE_CAP = 16;
	localparam int NUM_COEF = 10;

	localparam logic [46:0] PEAK_MAX = {47{1'b1}};
	localparam logic [96:0] RND32 = 97'(1) << 31;
	localparam logic [96:0] RND16 = 97'(1) << 15;

	localparam logic [31:0] SAMPLE_INTERVAL_RST = 32'd42949673;
	localparam logic REG_SAMPLE_INTERVAL = 1'b0;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// terms of one lane update, in issue order
	localparam logic [3:0] JOB_U_DISP = 4'd0;
	localparam logic [3:0] JOB_U_CUR = 4'd3;
	localparam logic [3:0] JOB_V_CUR = 4'd7;
	localparam logic [3:0] JOB_DAMP = 4'd8;
	localparam logic [3:0] JOB_STIFF = 4'd9;

	// operand kinds of the state terms
	localparam logic [1:0] OPND_DISP = 2'd0;
	localparam logic [1:0] OPND_VEL = 2'd1;
	localparam logic [1:0] OPND_PREV = 2'd2;
	localparam logic [1:0] OPND_CUR = 2'd3;

	typedef struct packed {
		logic is_sample;
		logic [3:0] lane;
		logic [3:0] sel;
		logic signed [47:0] value;
		logic signed [23:0] sample;
		logic first;
		logic last;
	} cmd_t;

	function automatic logic [3:0] job_coef(input logic [3:0] job);
		logic [3:0] sel;
		case (job)
			4'd2: sel = 4'd4;
			4'd3: sel = 4'd5;
			4'd4: sel = 4'd2;
			4'd5: sel = 4'd3;
			default: sel = job;
		endcase
		return sel;
	endfunction

	function automatic logic [47:0] mag48(input logic signed [47:0] x);
		return x[47] ? 48'(-x) : 48'(x);
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [50:0] x);
		logic signed [47:0] r;
		if (x > 51'sh0_7FFF_FFFF_FFFF)
			r = 48'sh7FFF_FFFF_FFFF;
		else if (x < -51'sh0_8000_0000_0000)
			r = 48'sh8000_0000_0000;
		else
			r = x[47:0];
		return r;
	endfunction

	function automatic logic [46:0] peak_of(input logic signed [47:0] x);
		logic [47:0] m;
		m = mag48(x);
		return (m > 48'(PEAK_MAX)) ? PEAK_MAX : m[46:0];
	endfunction

endpackage

// File: src/rspb_ram.sv
// ----------------------------------------------------------------------------
// rspb_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rspb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 160,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/rspb_front.sv
// ----------------------------------------------------------------------------
// rspb_front
// accepts input beats, drops loads that address nothing, queues commands
// ----------------------------------------------------------------------------
module rspb_front #(
	parameter int LANES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rspb_pkg::cmd_t in_cmd,
	output logic          q_valid,
	input  logic          q_ready,
	output rspb_pkg::cmd_t q_cmd
);
	import rspb_pkg::*;

	cmd_t fifo_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic keep, push, pop;

	assign keep = in_cmd.is_sample ||
		((32'(in_cmd.lane) < LANES) && (32'(in_cmd.sel) < NUM_COEF));
	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready && keep;
	assign q_valid = (count_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: src/rspb_back.sv
// ----------------------------------------------------------------------------
// rspb_back
// lane sequencer with a shared multiply accumulate datapath and result buffer
// ----------------------------------------------------------------------------
module rspb_back #(
	parameter int LANES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [31:0]    sample_interval,
	input  logic           q_valid,
	output logic           q_ready,
	input  rspb_pkg::cmd_t q_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [3:0]     out_lane,
	output logic [46:0]    out_peak,
	output logic           out_last
);
	import rspb_pkg::*;

	localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int DEPTH = LANES * NUM_COEF;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [LW-1:0] LAST_LANE = LW'(LANES - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SDT = 3'd1;
	localparam logic [2:0] ST_RD = 3'd2;
	localparam logic [2:0] ST_OPS = 3'd3;
	localparam logic [2:0] ST_MUL = 3'd4;
	localparam logic [2:0] ST_FIN = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0] state_q;
	cmd_t cmd_q;
	logic [LW-1:0] lane_q, emit_q;
	logic [3:0] job_q;
	logic [1:0] part_q;
	logic [47:0] a_q, b_q;
	logic neg_q, sh32_q;
	logic [95:0] prod_q;
	logic signed [50:0] sum_q;
	logic signed [47:0] un_q, vn_q, sdt_q;
	logic signed [23:0] prev_q;
	logic signed [47:0] disp_q [LANES];
	logic signed [47:0] vel_q [LANES];
	logic [46:0] peak_q [LANES];

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [47:0] ram_rdata;

	logic signed [47:0] coef, opnd;
	logic [23:0] pa, pb;
	logic [47:0] pp;
	logic [95:0] pp_sh;
	logic [96:0] rnd, shf, lim;
	logic [47:0] mres;
	logic signed [47:0] res;
	logic signed [50:0] sum_next;
	logic signed [47:0] acc_sat;
	logic [46:0] new_peak;
	logic [47:0] cur_mag;
	logic [55:0] sdt_prod;
	logic [39:0] sdt_mag;
	logic out_load, last_job;

	assign q_ready = (state_q == ST_IDLE);
	assign ram_we = q_valid && q_ready && !q_cmd.is_sample;
	assign ram_waddr = AW'(int'(q_cmd.lane) * NUM_COEF + int'(q_cmd.sel));
	assign ram_raddr = AW'(int'(lane_q) * NUM_COEF + int'(job_coef(job_q)));

	rspb_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_coef_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(q_cmd.value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		coef = ram_rdata;
		if (job_q == JOB_DAMP)
			opnd = cmd_q.first ? sdt_q : vn_q;
		else if (job_q == JOB_STIFF)
			opnd = un_q;
		else begin
			case (job_q[1:0])
				OPND_DISP: opnd = disp_q[lane_q];
				OPND_VEL: opnd = vel_q[lane_q];
				OPND_PREV: opnd = 48'(prev_q);
				default: opnd = 48'(cmd_q.sample);
			endcase
		end
	end

	always_comb begin
		pa = part_q[1] ? a_q[47:24] : a_q[23:0];
		pb = part_q[0] ? b_q[47:24] : b_q[23:0];
		pp = pa * pb;
		case (part_q)
			2'b00: pp_sh = {48'd0, pp};
			2'b11: pp_sh = {pp, 48'd0};
			default: pp_sh = {24'd0, pp, 24'd0};
		endcase
	end

	always_comb begin
		rnd = {1'b0, prod_q} + (sh32_q ? RND32 : RND16);
		shf = sh32_q ? (rnd >> 32) : (rnd >> 16);
		lim = neg_q ? (97'(PEAK_MAX) + 97'd1) : 97'(PEAK_MAX);
		mres = (shf > lim) ? lim[47:0] : shf[47:0];
		res = neg_q ? -$signed(mres) : $signed(mres);
		sum_next = sum_q + {{3{res[47]}}, res};
		acc_sat = sat48(sum_next);
		new_peak = peak_of(cmd_q.first ? res : acc_sat);
		last_job = cmd_q.first || (job_q == JOB_STIFF);
	end

	always_comb begin
		cur_mag = mag48(48'(cmd_q.sample));
		sdt_prod = 56'(cur_mag[23:0]) * 56'(sample_interval);
		sdt_mag = 40'((sdt_prod + 56'(RND16)) >> 16);
	end

	assign out_load = (state_q == ST_EMIT) && (!out_valid || out_ready);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid)
					cmd_q <= q_cmd;
				sum_q <= '0;
			end
			ST_SDT: begin
				sdt_q <= cmd_q.sample[23] ? -$signed(48'(sdt_mag)) : $signed(48'(sdt_mag));
			end
			ST_OPS: begin
				a_q <= mag48(coef);
				b_q <= mag48(opnd);
				neg_q <= coef[47] ^ opnd[47];
				sh32_q <= !(job_q < JOB_DAMP &&
					(job_q[1:0] == OPND_PREV || job_q[1:0] == OPND_CUR));
				prod_q <= '0;
			end
			ST_MUL: begin
				prod_q <= prod_q + pp_sh;
			end
			ST_FIN: begin
				if (!cmd_q.first) begin
					if (job_q == JOB_U_CUR) begin
						un_q <= acc_sat;
						sum_q <= '0;
					end else if (job_q == JOB_V_CUR) begin
						vn_q <= acc_sat;
						sum_q <= '0;
					end else if (job_q == JOB_STIFF)
						sum_q <= '0;
					else
						sum_q <= sum_next;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_lane <= 4'(emit_q);
			out_peak <= peak_q[emit_q];
			out_last <= (emit_q == LAST_LANE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q <= '0;
			emit_q <= '0;
			job_q <= '0;
			part_q <= '0;
			prev_q <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				disp_q[i] <= '0;
				vel_q[i] <= '0;
				peak_q[i] <= '0;
			end
		end else begin
			if (out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && q_cmd.is_sample) begin
						lane_q <= '0;
						job_q <= q_cmd.first ? JOB_DAMP : JOB_U_DISP;
						state_q <= q_cmd.first ? ST_SDT : ST_RD;
					end
				end
				ST_SDT: state_q <= ST_RD;
				ST_RD: state_q <= ST_OPS;
				ST_OPS: begin
					part_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (last_job) begin
						if (cmd_q.first) begin
							disp_q[lane_q] <= '0;
							vel_q[lane_q] <= -sdt_q;
							peak_q[lane_q] <= new_peak;
						end else begin
							disp_q[lane_q] <= un_q;
							vel_q[lane_q] <= vn_q;
							if (new_peak > peak_q[lane_q])
								peak_q[lane_q] <= new_peak;
						end
						if (lane_q == LAST_LANE) begin
							prev_q <= cmd_q.sample;
							emit_q <= '0;
							state_q <= cmd_q.last ? ST_EMIT : ST_IDLE;
						end else begin
							lane_q <= lane_q + LW'(1);
							job_q <= cmd_q.first ? JOB_DAMP : JOB_U_DISP;
							state_q <= ST_RD;
						end
					end else begin
						job_q <= job_q + 4'd1;
						state_q <= ST_RD;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (emit_q == LAST_LANE)
							state_q <= ST_IDLE;
						else
							emit_q <= emit_q + LW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/response_spectrum_peak_bank.sv
// ----------------------------------------------------------------------------
// response_spectrum_peak_bank
// bank of damped oscillators tracking peak absolute acceleration per lane
// ----------------------------------------------------------------------------
// load beat: writes one coefficient; sample beat: updates the N lanes one after another
// each lane runs ten terms (one on a first sample) through one 24x24 multiplier, four partial products per term
// last sample: N result beats follow, one per cycle while m_axis_tready is high
// arst_n clears lane state, queue and output; coefficient memory is not cleared
module response_spectrum_peak_bank #(
	parameter int NUM_LANES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// lane_index, coeff_select, coeff_value, sample
	input  logic [79:0] s_axis_tdata,
	// operation, first_sample
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_lane, peak_accel, zero pad
	output logic [55:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import rspb_pkg::*;

	localparam int LANES = (NUM_LANES < LANE_CAP) ? NUM_LANES : LANE_CAP;

	logic [31:0] sample_interval_q;
	cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;
	logic [3:0] out_lane;
	logic [46:0] out_peak;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SAMPLE_INTERVAL) ? sample_interval_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sample_interval_q <= SAMPLE_INTERVAL_RST;
		else if (psel && penable && pwrite && pready && paddr[2] == REG_SAMPLE_INTERVAL)
			sample_interval_q <= pwdata;
	end

	always_comb begin
		in_cmd.is_sample = (s_axis_tuser[0] == OP_SAMPLE);
		in_cmd.lane = s_axis_tdata[3:0];
		in_cmd.sel = s_axis_tdata[7:4];
		in_cmd.value = s_axis_tdata[55:8];
		in_cmd.sample = s_axis_tdata[79:56];
		in_cmd.first = s_axis_tuser[1];
		in_cmd.last = s_axis_tlast;
	end

	rspb_front #(.LANES(LANES)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_cmd(in_cmd),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_cmd(q_cmd)
	);

	rspb_back #(.LANES(LANES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.sample_interval(sample_interval_q),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_cmd(q_cmd),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_lane(out_lane),
		.out_peak(out_peak),
		.out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, out_peak, out_lane};

endmodule

// File: src/rspb_checker.sv
// ----------------------------------------------------------------------------
// rspb_checker
// port level checks of the response spectrum peak bank
// ----------------------------------------------------------------------------
`include "response_spectrum_peak_bank_assert.svh"

module rspb_checker #(
	parameter int NUM_LANES = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	localparam int LANES = (NUM_LANES < 16) ? NUM_LANES : 16;

	`RSPB_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat dropped or changed while stalled")
	`RSPB_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_axis_tvalid, "result beat shown during reset")
	`RSPB_ASSERT(a_last_lane, clk, arst_n, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == 4'(LANES - 1), "last beat not on top lane")
	`RSPB_ASSERT(a_next_lane, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !m_axis_tvalid || m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1, "result lanes out of order")
	`RSPB_ASSERT_ALWAYS(a_pready, clk, pready, "pready low")

endmodule

bind response_spectrum_peak_bank rspb_checker #(.NUM_LANES(NUM_LANES)) u_rspb_checker (.*);

// File: tb/sv/response_spectrum_peak_bank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_spectrum_peak_bank_tb
// self-checking bench for the response spectrum peak bank: coefficient loads
// and acceleration records go in on the input stream, an in-bench fixed-point
// oscillator model predicts every lane peak, and each output beat is checked
// against it with random stalls on both streams and several time steps
// ----------------------------------------------------------------------------
module response_spectrum_peak_bank_tb;
	import rspb_pkg::*;

	localparam logic [3:0] SEL_A11 = 4'd0;
	localparam logic [3:0] SEL_A12 = 4'd1;
	localparam logic [3:0] SEL_A21 = 4'd2;
	localparam logic [3:0] SEL_A22 = 4'd3;
	localparam logic [3:0] SEL_B11 = 4'd4;
	localparam logic [3:0] SEL_B12 = 4'd5;
	localparam logic [3:0] SEL_B21 = 4'd6;
	localparam logic [3:0] SEL_B22 = 4'd7;
	localparam logic [3:0] SEL_TWO_DAMP_OMEGA = 4'd8;
	localparam logic [3:0] SEL_OMEGA_SQ = 4'd9;
	localparam logic [2:0] ADDR_SAMPLE_INTERVAL = 3'd0;
	localparam int SETTLE_CYCLES = 4000;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

	typedef struct {
		logic [3:0] lane;
		logic [46:0] peak;
		logic last;
	} peak_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic s_axis_tvalid, s_axis_tready;
	// lane_index, coeff_select, coeff_value, sample
	logic [79:0] s_axis_tdata;
	// operation, first_sample
	logic [1:0] s_axis_tuser;
	logic s_axis_tlast;
	logic m_axis_tvalid, m_axis_tready;
	// result_lane, peak_accel, zero pad
	logic [55:0] m_axis_tdata;
	logic m_axis_tlast;

	response_spectrum_peak_bank i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always #6 clk = ~clk;

	// oscillator bank model
	logic [31:0] dt_q;
	logic signed [47:0] coef_tbl [LANE_CAP][NUM_COEF];
	logic signed [47:0] disp_q [LANE_CAP];
	logic signed [47:0] vel_q [LANE_CAP];
	logic [46:0] peak_q [LANE_CAP];
	logic signed [23:0] prev_smp;
	peak_beat_t peak_exp_q [$];

	bit calm = 0;
	int n_err = 0, n_samples = 0, n_loads = 0, n_peaks = 0, n_records = 0;
	int cycles = 0;
	int stall_left = 0;

	function automatic logic [47:0] abs48(logic signed [47:0] x);
		return x[47] ? 48'(-x) : 48'(x);
	endfunction

	function automatic logic signed [47:0] fix_mul(logic signed [47:0] a,
			logic signed [47:0] b, int sh);
		logic [95:0] m;
		logic [47:0] lim;
		logic neg;
		neg = a[47] ^ b[47];
		m = 96'(abs48(a)) * 96'(abs48(b));
		m = (m + (96'(1) << (sh - 1))) >> sh;
		lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		if (m > 96'(lim))
			m = 96'(lim);
		return neg ? -$signed(m[47:0]) : $signed(m[47:0]);
	endfunction

	function automatic logic signed [47:0] clamp48(logic signed [63:0] x);
		if (x > 64'(MAX48))
			return MAX48;
		if (x < 64'(MIN48))
			return MIN48;
		return x[47:0];
	endfunction

	function automatic logic [46:0] peak_clip(logic signed [63:0] x);
		logic [63:0] m;
		m = x[63] ? 64'(-x) : 64'(x);
		return (m > 64'(PEAK_MAX)) ? PEAK_MAX : m[46:0];
	endfunction

	function automatic void oscillator_advance(logic op, logic [3:0] lane,
			logic [3:0] sel, logic signed [47:0] val, logic signed [23:0] smp,
			logic first, logic last);
		logic [63:0] m;
		logic signed [47:0] sdt, cur, prv, u, v, un, vn;
		logic signed [63:0] acc;
		peak_beat_t b;
		if (op == OP_LOAD) begin
			if (sel <= SEL_OMEGA_SQ)
				coef_tbl[lane][sel] = val;
			return;
		end
		cur = 48'(smp);
		prv = 48'(prev_smp);
		if (first) begin
			m = ((64'(abs48(cur)) * 64'(dt_q)) + 64'h8000) >> 16;
			sdt = cur[47] ? -$signed(m[47:0]) : $signed(m[47:0]);
			for (int l = 0; l < LANE_CAP; l++) begin
				disp_q[l] = '0;
				vel_q[l] = -sdt;
				peak_q[l] = peak_clip(64'(fix_mul(coef_tbl[l][SEL_TWO_DAMP_OMEGA], sdt, 32)));
			end
		end else begin
			for (int l = 0; l < LANE_CAP; l++) begin
				u = disp_q[l];
				v = vel_q[l];
				un = clamp48(64'(fix_mul(coef_tbl[l][SEL_A11], u, 32))
					+ 64'(fix_mul(coef_tbl[l][SEL_A12], v, 32))
					+ 64'(fix_mul(coef_tbl[l][SEL_B11], prv, 16))
					+ 64'(fix_mul(coef_tbl[l][SEL_B12], cur, 16)));
				vn = clamp48(64'(fix_mul(coef_tbl[l][SEL_A21], u, 32))
					+ 64'(fix_mul(coef_tbl[l][SEL_A22], v, 32))
					+ 64'(fix_mul(coef_tbl[l][SEL_B21], prv, 16))
					+ 64'(fix_mul(coef_tbl[l][SEL_B22], cur, 16)));
				acc = -64'(clamp48(64'(fix_mul(coef_tbl[l][SEL_TWO_DAMP_OMEGA], vn, 32))
					+ 64'(fix_mul(coef_tbl[l][SEL_OMEGA_SQ], un, 32))));
				if (peak_clip(acc) > peak_q[l])
					peak_q[l] = peak_clip(acc);
				disp_q[l] = un;
				vel_q[l] = vn;
			end
		end
		prev_smp = smp;
		if (last) begin
			for (int l = 0; l < LANE_CAP; l++) begin
				b.lane = 4'(l);
				b.peak = peak_q[l];
				b.last = (l == LANE_CAP - 1);
				peak_exp_q.push_back(b);
			end
			n_records++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		peak_beat_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_peaks++;
			if (peak_exp_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected peak beat lane %0d peak %h", m_axis_tdata[3:0],
						m_axis_tdata[50:4]);
			end else begin
				e = peak_exp_q.pop_front();
				if (m_axis_tdata[3:0] !== e.lane || m_axis_tdata[50:4] !== e.peak
						|| m_axis_tlast !== e.last) begin
					n_err++;
					if (n_err <= 10)
						$display("peak mismatch: expected lane %0d peak %h last %b, got lane %0d peak %h last %b",
							e.lane, e.peak, e.last, m_axis_tdata[3:0], m_axis_tdata[50:4],
							m_axis_tlast);
				end
			end
		end
	end

	// output back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 17);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_beat(logic op, logic [3:0] lane, logic [3:0] sel,
			logic signed [47:0] val, logic signed [23:0] smp, logic first, logic last);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {smp, val, sel, lane};
		s_axis_tuser <= {first, op};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		oscillator_advance(op, lane, sel, val, smp, first, last);
		if (op == OP_SAMPLE)
			n_samples++;
		else
			n_loads++;
	endtask

	task automatic load_coef(logic [3:0] lane, logic [3:0] sel, logic signed [47:0] val);
		send_beat(OP_LOAD, lane, sel, val, 24'($urandom), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic send_sample(logic signed [23:0] smp, logic first, logic last);
		send_beat(OP_SAMPLE, 4'($urandom), 4'($urandom), 48'({$urandom, $urandom}),
			smp, first, last);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (peak_exp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_interval(logic [31:0] dt);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_SAMPLE_INTERVAL;
		pwdata <= dt;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		dt_q = dt;
	endtask

	function automatic logic signed [47:0] pick_coef(logic [3:0] sel);
		logic signed [47:0] r;
		r = 48'({$urandom, $urandom});
		if ($urandom_range(0, 9) == 0)
			return r;
		if (sel == SEL_A11 || sel == SEL_A22)
			return 48'sh1_0000_0000 + 48'($signed(r[28:0]));
		if (sel == SEL_OMEGA_SQ)
			return 48'($signed(r[40:0])) & 48'h7F_FFFF_FFFF;
		return 48'($signed(r[31:0]));
	endfunction

	task automatic test_load_all_lanes;
		for (int l = 0; l < LANE_CAP; l++)
			for (int s = 0; s < NUM_COEF; s++)
				load_coef(4'(l), 4'(s), pick_coef(4'(s)));
	endtask

	task automatic test_unmarked_start;
		send_sample(24'sh01_2345, 1'b0, 1'b0);
		send_sample(-24'sh00_4000, 1'b0, 1'b1);
	endtask

	task automatic test_bad_selects;
		for (int s = 10; s < 16; s++)
			load_coef(4'($urandom), 4'(s), 48'({$urandom, $urandom}));
		send_sample(24'sh00_8000, 1'b1, 1'b1);
	endtask

	task automatic test_sample_extremes;
		send_sample(24'sh7F_FFFF, 1'b1, 1'b0);
		send_sample(24'sh80_0000, 1'b0, 1'b0);
		send_sample(24'sh00_0000, 1'b0, 1'b0);
		send_sample(24'sh7F_FFFF, 1'b0, 1'b1);
	endtask

	task automatic test_extreme_coefs;
		load_coef(4'd15, SEL_A11, MAX48);
		load_coef(4'd15, SEL_A12, MIN48);
		load_coef(4'd15, SEL_B12, MAX48);
		load_coef(4'd15, SEL_TWO_DAMP_OMEGA, MIN48);
		load_coef(4'd15, SEL_OMEGA_SQ, MAX48);
		load_coef(4'd0, SEL_B22, 48'sh0);
		send_sample(24'sh80_0000, 1'b1, 1'b0);
		send_sample(24'sh7F_FFFF, 1'b0, 1'b1);
	endtask

	task automatic test_interval_sweep;
		logic [31:0] dts [4];
		dts = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, SAMPLE_INTERVAL_RST};
		foreach (dts[i]) begin
			set_interval(dts[i]);
			send_sample(24'($urandom), 1'b1, 1'b0);
			send_sample(24'($urandom), 1'b0, 1'b0);
			send_sample(24'($urandom), 1'b0, 1'b1);
		end
	endtask

	task automatic test_random_records;
		int len, target;
		target = n_samples + n_loads + 20;
		while (n_samples + n_loads < target) begin
			if (target - (n_samples + n_loads) < 8)
				calm = 1;
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 4))
					load_coef(4'($urandom), 4'($urandom_range(0, 11)),
						pick_coef(4'($urandom_range(0, 9))));
			case ($urandom_range(0, 9))
				0: send_sample(24'($urandom), 1'b1, 1'b1);
				1: send_sample(24'($urandom), 1'b0, 1'($urandom_range(0, 1)));
				2: set_interval($urandom);
				default: begin
					len = $urandom_range(1, 6);
					send_sample(24'($urandom), 1'b1, 1'b0);
					for (int i = 0; i < len; i++)
						send_sample(24'($urandom), 1'b0, i == len - 1);
				end
			endcase
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		s_axis_tlast <= 1'b0;
		m_axis_tready <= 1'b1;
		dt_q = SAMPLE_INTERVAL_RST;
		prev_smp = '0;
		for (int l = 0; l < LANE_CAP; l++) begin
			for (int s = 0; s < NUM_COEF; s++)
				coef_tbl[l][s] = '0;
			disp_q[l] = '0;
			vel_q[l] = '0;
			peak_q[l] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_all_lanes();
		test_unmarked_start();
		test_bad_selects();
		test_sample_extremes();
		test_extreme_coefs();
		test_interval_sweep();
		test_random_records();
		drain();

		$display("covered %0d samples, %0d coefficient loads, %0d records", n_samples,
			n_loads, n_records);
		$display("checked %0d peak beats, %0d mismatches", n_peaks, n_err);
		if (n_err == 0 && peak_exp_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/rspb_pkg.sv
src/rspb_ram.sv
src/rspb_front.sv
src/rspb_back.sv
src/response_spectrum_peak_bank.sv
src/rspb_checker.sv
tb/sv/response_spectrum_peak_bank_tb.sv
